@@ hdl/pwm_sound_sequencer_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PWM_SOUND_SEQUENCER_TOP_ASSERT_SVH
`define PWM_SOUND_SEQUENCER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ hdl/pss_pkg.sv @@
package pss_pkg;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  sample_byte;
      logic        last_byte;
      logic [7:0]  level_in;
      logic [15:0] frequency_hz;
      logic [15:0] duration_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] pwm_period;
      logic [15:0] pwm_compare;
      logic        amp_enable;
      logic        pwm_clock_on;
      logic [2:0]  mode_now;
      logic [7:0]  bytes_accepted;
      logic        finished;
   } rsp_type;

   localparam logic [2:0] OP_SAMPLE   = 3'd0;
   localparam logic [2:0] OP_MS       = 3'd1;
   localparam logic [2:0] OP_SVC      = 3'd2;
   localparam logic [2:0] OP_TONE     = 3'd3;
   localparam logic [2:0] OP_PLAY     = 3'd4;
   localparam logic [2:0] OP_BREAK    = 3'd5;
   localparam logic [2:0] OP_REPEAT   = 3'd6;
   localparam logic [2:0] OP_RESERVED = 3'd7;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_READY   = 3'd1;
   localparam logic [2:0] MODE_PLAY    = 3'd2;
   localparam logic [2:0] MODE_ONESHOT = 3'd3;
   localparam logic [2:0] MODE_MANUAL  = 3'd4;

   localparam logic [1:0] CSR_TONE_CLOCK = 2'd0;
   localparam logic [1:0] CSR_MIN_FREQ   = 2'd1;
   localparam logic [1:0] CSR_MAX_FREQ   = 2'd2;
   localparam logic [1:0] CSR_PCM_PERIOD = 2'd3;

   localparam logic [7:0] MAX_LEVEL = 8'd100;
   localparam logic [7:0] TONE_DIV  = 8'd200;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_DIV, ST_MUL, ST_SCALE, ST_RESP
   } state_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic div_start;
      logic div_step;
      logic tone_mul;
      logic scale_start;
      logic scale_step;
      logic tone_done;
      logic rsp_load;
   } cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic [2:0] operation;
      logic       div_last;
      logic       sample_wait;
   } stat_type;

endpackage

@@ hdl/pss_ctrl.sv @@
module pss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                csr_ready,
   output pss_pkg::cmd_type    cmd,
   input  pss_pkg::stat_type   stat
);

   pss_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // State and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != pss_pkg::ST_IDLE) || rsp_valid_ff;
   assign csr_ready = (state_ff == pss_pkg::ST_IDLE) && !rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = pss_pkg::ST_EXEC;
            end
         end
         pss_pkg::ST_EXEC: begin
            if (stat.operation == pss_pkg::OP_TONE) begin
               cmd.div_start = 1'b1;
               state_in      = pss_pkg::ST_DIV;
            end else if (stat.operation == pss_pkg::OP_SAMPLE && stat.sample_wait) begin
               // Sample memory read data settles in ST_SCALE before the sample is used.
               state_in = pss_pkg::ST_SCALE;
            end else begin
               cmd.exec = 1'b1;
               state_in = pss_pkg::ST_RESP;
            end
         end
         pss_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = pss_pkg::ST_MUL;
         end
         pss_pkg::ST_MUL: begin
            cmd.tone_mul    = 1'b1;
            cmd.scale_start = 1'b1;
            state_in        = pss_pkg::ST_SCALE;
         end
         pss_pkg::ST_SCALE: begin
            if (stat.operation == pss_pkg::OP_TONE) cmd.tone_done = 1'b1;
            else cmd.exec = 1'b1;
            state_in = pss_pkg::ST_RESP;
         end
         pss_pkg::ST_RESP: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = pss_pkg::ST_IDLE;
         end
         default: state_in = pss_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ hdl/pss_datapath.sv @@
module pss_datapath #(
   parameter int BUFFER_COUNT = 4,
   parameter int CHUNK_BYTES  = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  pss_pkg::req_type  req_data,
   output pss_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  pss_pkg::cmd_type  cmd,
   output pss_pkg::stat_type stat
);

   localparam int SW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
   localparam int PW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int DEPTH = BUFFER_COUNT * CHUNK_BYTES;
   localparam int AW = $clog2(DEPTH);
   localparam logic [7:0] CHUNK_MAX = 8'(CHUNK_BYTES);
   localparam logic [SW-1:0] SLOT_LAST = SW'(BUFFER_COUNT - 1);

   // Configuration registers.
   logic [31:0] tone_clock_ff;
   logic [15:0] min_freq_ff, max_freq_ff, pcm_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_clock_ff <= 32'd1031250;
         min_freq_ff   <= 16'd250;
         max_freq_ff   <= 16'd10000;
         pcm_period_ff <= 16'd2062;
      end else if (csr_write) begin
         case (csr_index)
            pss_pkg::CSR_TONE_CLOCK: tone_clock_ff <= csr_data;
            pss_pkg::CSR_MIN_FREQ:   min_freq_ff   <= csr_data[15:0];
            pss_pkg::CSR_MAX_FREQ:   max_freq_ff   <= csr_data[15:0];
            pss_pkg::CSR_PCM_PERIOD: pcm_period_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Captured request.
   pss_pkg::req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   // Sound state.
   logic [2:0]  mode_ff;
   logic [7:0]  volume_ff;
   logic [15:0] ms_left_ff, period_ff, compare_ff;
   logic        amp_ff, clk_on_ff;
   logic [7:0]  chunk_len_ff [BUFFER_COUNT];
   logic [SW-1:0] read_slot_ff, write_slot_ff;
   logic [7:0]  read_pos_ff, write_pos_ff;
   logic        write_reject_ff;
   logic [7:0]  accepted_ff;
   logic        fin_ff;

   // Sample memory with registered read.
   logic [7:0]  store_mem [DEPTH];
   logic [7:0]  store_rd_ff;
   logic        mem_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic        wr_rej_now;
   logic [7:0]  wpos_next;

   assign wr_addr = AW'(write_slot_ff) * AW'(CHUNK_BYTES) + AW'(write_pos_ff[PW-1:0]);
   assign rd_addr = AW'(read_slot_ff) * AW'(CHUNK_BYTES) + AW'(read_pos_ff[PW-1:0]);

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[wr_addr] <= req_ff.sample_byte;
      store_rd_ff <= store_mem[rd_addr];
   end

   // Iterative restoring divider for the tone period.
   logic [15:0] freq_ff;
   logic [31:0] quot_ff;
   logic [31:0] rem_ff;
   logic [4:0]  div_cnt_ff;
   logic [16:0] rem_shift;
   logic [15:0] freq_clamp;

   always_comb begin
      if (req_ff.frequency_hz < min_freq_ff) freq_clamp = min_freq_ff;
      else if (req_ff.frequency_hz > max_freq_ff) freq_clamp = max_freq_ff;
      else freq_clamp = req_ff.frequency_hz;
   end

   assign rem_shift = {rem_ff[15:0], quot_ff[31]};
   assign stat.div_last = (div_cnt_ff == 5'd31);
   assign stat.operation = req_ff.operation;
   assign stat.sample_wait = (mode_ff == pss_pkg::MODE_PLAY) &&
                             (chunk_len_ff[read_slot_ff] != 8'd0);

   // Product and divide-by-200 for the compare value.
   logic [23:0] prod_ff;
   logic [7:0]  lvl_clamp;
   logic [15:0] period_q;
   logic [15:0] cmp_div;
   logic [47:0] recip;

   assign lvl_clamp = (req_ff.level_in > pss_pkg::MAX_LEVEL) ? pss_pkg::MAX_LEVEL
                                                              : req_ff.level_in;
   assign period_q = quot_ff[15:0] - 16'd1;
   // Divide by 200 via multiply by ceil(2^31/200) = 10737419, exact for products
   // below 14 million; a 16-bit period times a level of at most 100 stays below that.
   assign recip  = 48'(prod_ff) * 48'd10737419;
   assign cmp_div = recip[31+:16];

   logic [7:0] sample_eff;
   assign sample_eff = (store_rd_ff == 8'd0) ? 8'd1 : store_rd_ff;

   // Chunk rejection is decided at the first byte and held for the rest.
   assign wr_rej_now = (write_pos_ff == 8'd0) ? (chunk_len_ff[write_slot_ff] != 8'd0)
                                              : write_reject_ff;
   assign wpos_next = (write_pos_ff < CHUNK_MAX) ? write_pos_ff + 8'd1 : write_pos_ff;
   assign mem_we = cmd.exec && req_ff.operation == pss_pkg::OP_SVC &&
                   !wr_rej_now && write_pos_ff < CHUNK_MAX;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         freq_ff    <= freq_clamp;
         quot_ff    <= tone_clock_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 5'd1;
         if (freq_ff == 16'd0) begin
            quot_ff <= 32'hFFFF_FFFF;
         end else if (rem_shift >= {1'b0, freq_ff}) begin
            rem_ff  <= 32'(rem_shift - {1'b0, freq_ff});
            quot_ff <= {quot_ff[30:0], 1'b1};
         end else begin
            rem_ff  <= 32'(rem_shift);
            quot_ff <= {quot_ff[30:0], 1'b0};
         end
      end
      if (cmd.tone_mul) prod_ff <= 24'(period_q) * 24'(lvl_clamp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= pss_pkg::MODE_IDLE;
         volume_ff       <= '0;
         ms_left_ff      <= '0;
         period_ff       <= '0;
         compare_ff      <= '0;
         amp_ff          <= 1'b0;
         clk_on_ff       <= 1'b0;
         for (int i = 0; i < BUFFER_COUNT; i++) chunk_len_ff[i] <= '0;
         read_slot_ff    <= '0;
         write_slot_ff   <= '0;
         read_pos_ff     <= '0;
         write_pos_ff    <= '0;
         write_reject_ff <= 1'b0;
         accepted_ff     <= '0;
         fin_ff          <= 1'b0;
      end else begin
         if (cmd.load) begin
            accepted_ff <= '0;
            fin_ff      <= 1'b0;
         end
         // Tone command finishes after divide and multiply.
         if (cmd.tone_done) begin
            period_ff  <= period_q;
            volume_ff  <= lvl_clamp;
            compare_ff <= cmp_div;
            clk_on_ff  <= 1'b1;
            amp_ff     <= 1'b1;
            ms_left_ff <= req_ff.duration_ms;
            mode_ff    <= (req_ff.duration_ms != 16'd0) ? pss_pkg::MODE_ONESHOT
                                                        : pss_pkg::MODE_MANUAL;
         end
         if (cmd.exec) begin
            case (req_ff.operation)
               pss_pkg::OP_SAMPLE: begin
                  if (mode_ff == pss_pkg::MODE_READY) begin
                     if (chunk_len_ff[read_slot_ff] != 8'd0) mode_ff <= pss_pkg::MODE_PLAY;
                  end else if (mode_ff == pss_pkg::MODE_PLAY) begin
                     if (chunk_len_ff[read_slot_ff] != 8'd0) begin
                        compare_ff <= (read_pos_ff < CHUNK_MAX)
                                      ? 16'(volume_ff) * 16'(sample_eff)
                                      : 16'(volume_ff);
                        chunk_len_ff[read_slot_ff] <= chunk_len_ff[read_slot_ff] - 8'd1;
                        if (chunk_len_ff[read_slot_ff] == 8'd1) begin
                           read_pos_ff  <= '0;
                           read_slot_ff <= (read_slot_ff == SLOT_LAST) ? '0
                                                                       : read_slot_ff + SW'(1);
                        end else begin
                           read_pos_ff <= read_pos_ff + 8'd1;
                        end
                     end else begin
                        amp_ff  <= 1'b0;
                        mode_ff <= pss_pkg::MODE_IDLE;
                        fin_ff  <= 1'b1;
                     end
                  end
               end
               pss_pkg::OP_MS: begin
                  if (mode_ff == pss_pkg::MODE_ONESHOT) begin
                     if (ms_left_ff <= 16'd1) begin
                        ms_left_ff <= '0;
                        clk_on_ff  <= 1'b0;
                        amp_ff     <= 1'b0;
                        mode_ff    <= pss_pkg::MODE_IDLE;
                        fin_ff     <= 1'b1;
                     end else begin
                        ms_left_ff <= ms_left_ff - 16'd1;
                     end
                  end
               end
               pss_pkg::OP_SVC: begin
                  if (req_ff.last_byte) begin
                     if (!wr_rej_now) begin
                        chunk_len_ff[write_slot_ff] <= wpos_next;
                        accepted_ff   <= wpos_next;
                        write_slot_ff <= (write_slot_ff == SLOT_LAST) ? '0
                                                                      : write_slot_ff + SW'(1);
                     end
                     write_pos_ff    <= '0;
                     write_reject_ff <= 1'b0;
                  end else begin
                     write_pos_ff    <= wpos_next;
                     write_reject_ff <= wr_rej_now;
                  end
               end
               pss_pkg::OP_PLAY: begin
                  volume_ff       <= req_ff.level_in;
                  period_ff       <= pcm_period_ff;
                  clk_on_ff       <= 1'b1;
                  write_slot_ff   <= '0;
                  read_slot_ff    <= '0;
                  read_pos_ff     <= '0;
                  write_pos_ff    <= '0;
                  write_reject_ff <= 1'b0;
                  for (int i = 0; i < BUFFER_COUNT; i++) chunk_len_ff[i] <= '0;
                  mode_ff         <= pss_pkg::MODE_READY;
                  amp_ff          <= (req_ff.level_in != 8'd0);
                  accepted_ff     <= 8'd2;
               end
               pss_pkg::OP_BREAK: begin
                  mode_ff   <= pss_pkg::MODE_IDLE;
                  amp_ff    <= 1'b0;
                  clk_on_ff <= 1'b0;
                  fin_ff    <= 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // Output register, held while the receiver stalls.
   pss_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.pwm_period     <= period_ff;
         rsp_ff.pwm_compare    <= compare_ff;
         rsp_ff.amp_enable     <= amp_ff;
         rsp_ff.pwm_clock_on   <= clk_on_ff;
         rsp_ff.mode_now       <= mode_ff;
         rsp_ff.bytes_accepted <= accepted_ff;
         rsp_ff.finished       <= fin_ff;
      end
   end
   assign rsp_data = rsp_ff;

   logic unused_scale;
   assign unused_scale = cmd.scale_start ^ cmd.scale_step ^ (|rem_ff[31:17]) ^ (|recip[47:0])
                         ^ (|pss_pkg::TONE_DIV);

endmodule

@@ hdl/pwm_sound_sequencer_top.sv @@
// PWM sound sequencer.
// Input channel req_*: one command, sample tick, ms tick or service byte per
// transaction, accepted when req_valid is high and req_stall is low.
// Output channel rsp_*: exactly one result per input transaction, in order,
// taken when rsp_valid is high and rsp_stall is low.
// csr_*: configuration writes (tone_clock, min_freq, max_freq, pcm_period),
// taken while the block is idle.
// Path: ticks, bytes, play and break pass ST_EXEC and ST_RESP; a sample tick
// during playback also waits in ST_SCALE for the sample memory read; a tone
// command runs the 32-step bit-serial period divider, then the duty multiply.
// One transaction is worked on at a time; the next is accepted once the
// controller is idle again and the result register is free.
// Reset clears modes, counters, chunk lengths and configuration to defaults;
// the sample memory needs no clearing since only filled chunks are read.
// While the receiver stalls the result is held and req_stall stays high.
module pwm_sound_sequencer_top #(
   parameter int BUFFER_COUNT = 4,
   parameter int CHUNK_BYTES  = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pss_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);

   pss_pkg::cmd_type  cmd;
   pss_pkg::stat_type stat;

   pss_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .csr_ready, .cmd, .stat
   );

   pss_datapath #(.BUFFER_COUNT(BUFFER_COUNT), .CHUNK_BYTES(CHUNK_BYTES)) u_dp (
      .clock, .reset, .req_data, .rsp_data,
      .csr_write(csr_valid && csr_ready), .csr_index, .csr_data, .cmd, .stat
   );

endmodule

@@ hdl/pss_checker.sv @@
`include "pwm_sound_sequencer_top_assert.svh"
module pss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pss_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready
);
   // A stalled result keeps its contents.
   `PSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // No new transaction is taken while a result waits.
   `PSS_ASSERT_IMPL(a_no_accept_busy, clock, reset, req_valid && !req_stall, !rsp_valid)
   // Configuration is only taken while no transaction is in flight.
   `PSS_ASSERT_IMPL(a_csr_idle, clock, reset, csr_valid && csr_ready, !req_stall)
   // A sound that ends always leaves the amplifier off.
   `PSS_ASSERT_IMPL(a_fin_amp, clock, reset, rsp_valid && rsp_data.finished,
                    !rsp_data.amp_enable)
endmodule

bind pwm_sound_sequencer_top pss_checker u_chk (.*);
